// ===== rtl/rational_add_reduce_unit_assert.svh =====
// Assertion macros shared by the rational add/reduce unit modules.
`ifndef RATIONAL_ADD_REDUCE_UNIT_ASSERT_SVH
`define RATIONAL_ADD_REDUCE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rar_pkg.sv =====
// Package with the types, codes and helper functions of the rational add/reduce unit.
`timescale 1ns / 1ps

package rar_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        ACT_REDUCE  = 2'd0,
        ACT_ADD     = 2'd1,
        ACT_ADD_INT = 2'd2,
        ACT_COMPARE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        JOB_REDUCE,
        JOB_ADD,
        JOB_ADD_INT,
        JOB_DIRECT
    } job_t;

    typedef struct packed {
        job_t               job;
        logic signed [31:0] ln;
        logic signed [31:0] ld;
        logic signed [31:0] rn;
        logic signed [31:0] rd;
        logic               is_equal;
        status_t            status;
    } job_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_PREP,
        BK_GCD,
        BK_SHIFT,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // True when a sign and magnitude pair fits a signed value of w bits.
    function automatic logic fits_width(input logic neg, input logic [63:0] mag,
                                        input int w);
        logic [63:0] lim;
        lim = 64'd1 << (w - 1);
        return neg ? (mag <= lim) : (mag < lim);
    endfunction

    // Builds the 32-bit two's complement value of a sign and magnitude pair.
    function automatic logic [31:0] to_signed32(input logic neg, input logic [63:0] mag);
        logic [63:0] v;
        v = neg ? (~mag + 64'd1) : mag;
        return v[31:0];
    endfunction

endpackage

// ===== rtl/rar_front.sv =====
// Front end: sign-extends the operands, decodes the action and classifies each beat.
`timescale 1ns / 1ps

module rar_front #(
    parameter int VALUE_WIDTH = rar_pkg::VALUE_WIDTH_DEF
) (
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [127:0]       s_axis_tdata,
    input  logic [1:0]         s_axis_tuser,
    input  logic               q_full,
    output logic               q_push,
    output rar_pkg::job_entry_t q_entry
);

    localparam int SH = 32 - VALUE_WIDTH;

    logic signed [31:0] ln;
    logic signed [31:0] ld;
    logic signed [31:0] rn;
    logic signed [31:0] rd;
    rar_pkg::action_t   action;

    assign ln = $signed(s_axis_tdata[31:0]   << SH) >>> SH;
    assign ld = $signed(s_axis_tdata[63:32]  << SH) >>> SH;
    assign rn = $signed(s_axis_tdata[95:64]  << SH) >>> SH;
    assign rd = $signed(s_axis_tdata[127:96] << SH) >>> SH;
    assign action = rar_pkg::action_t'(s_axis_tuser);

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb begin
        q_entry.ln       = ln;
        q_entry.ld       = ld;
        q_entry.rn       = rn;
        q_entry.rd       = rd;
        q_entry.is_equal = 1'b0;
        q_entry.status   = rar_pkg::ST_OK;
        q_entry.job      = rar_pkg::JOB_DIRECT;
        unique case (action)
            rar_pkg::ACT_REDUCE: begin
                if (ld == 32'sd0) begin
                    q_entry.status = rar_pkg::ST_ZERO_DEN;
                end else begin
                    q_entry.job = rar_pkg::JOB_REDUCE;
                end
            end
            rar_pkg::ACT_ADD: begin
                if (ld == 32'sd0 || rd == 32'sd0) begin
                    q_entry.status = rar_pkg::ST_ZERO_DEN;
                end else begin
                    q_entry.job = rar_pkg::JOB_ADD;
                end
            end
            rar_pkg::ACT_ADD_INT: begin
                if (ld == 32'sd0) begin
                    q_entry.status = rar_pkg::ST_ZERO_DEN;
                end else begin
                    q_entry.job = rar_pkg::JOB_ADD_INT;
                end
            end
            default: begin
                q_entry.is_equal = (ln == rn) && (ld == rd);
            end
        endcase
    end

endmodule

// ===== rtl/rar_queue.sv =====
// Short queue of classified jobs between the front end and the arithmetic engine.
`timescale 1ns / 1ps
`include "rational_add_reduce_unit_assert.svh"

module rar_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rar_pkg::job_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output rar_pkg::job_entry_t head_entry
);

    localparam int DEPTH = rar_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rar_pkg::job_entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `RAR_ASSERT_SAME(a_no_push_full, aclk, aresetn, push, count_reg != CNT_W'(DEPTH), "push into full queue")

endmodule

// ===== rtl/rar_back.sv =====
// Arithmetic engine: products, sum, binary gcd, serial division and the output register.
`timescale 1ns / 1ps
`include "rational_add_reduce_unit_assert.svh"

module rar_back #(
    parameter int VALUE_WIDTH = rar_pkg::VALUE_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  rar_pkg::job_entry_t q_entry,
    output logic                q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [71:0]         m_axis_tdata,
    output logic [1:0]          m_axis_tuser
);

    rar_pkg::back_state_t state_reg, state_next;
    rar_pkg::job_t        job_reg;
    logic signed [31:0]   ln_reg, ld_reg, rn_reg, rd_reg;
    logic [1:0]           mul_cnt_reg;
    logic signed [63:0]   prod_a_reg, prod_b_reg, prod_c_reg;
    logic signed [64:0]   sum_reg;
    logic signed [63:0]   dsrc_reg;
    logic                 nneg_reg, dneg_reg;
    logic [63:0]          a_reg, b_reg, g_reg;
    logic [5:0]           k_reg;
    logic [63:0]          qn_reg, qd_reg;
    logic [64:0]          remn_reg, remd_reg;
    logic [5:0]           div_cnt_reg;
    logic [31:0]          res_num_reg, res_den_reg;
    logic                 res_eq_reg;
    rar_pkg::status_t     res_st_reg;

    logic                 out_valid_reg;
    logic [31:0]          out_num_reg, out_den_reg;
    logic                 out_eq_reg;
    rar_pkg::status_t     out_st_reg;

    logic                 load_out;
    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   product;
    logic [64:0]          remn_sh, remd_sh, g_ext;
    logic [64:0]          sum_mag;
    logic [63:0]          dsrc_mag;
    logic                 fin_fit;
    logic [31:0]          fin_num, fin_den;
    rar_pkg::status_t     fin_st;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rar_pkg::BK_IDLE: begin
                if (q_valid) begin
                    unique case (q_entry.job)
                        rar_pkg::JOB_DIRECT: state_next = rar_pkg::BK_DONE;
                        rar_pkg::JOB_REDUCE: state_next = rar_pkg::BK_SUM;
                        default:             state_next = rar_pkg::BK_MUL;
                    endcase
                end
            end
            rar_pkg::BK_MUL: begin
                if (job_reg == rar_pkg::JOB_ADD_INT || mul_cnt_reg == 2'd2) begin
                    state_next = rar_pkg::BK_SUM;
                end
            end
            rar_pkg::BK_SUM:  state_next = rar_pkg::BK_PREP;
            rar_pkg::BK_PREP: begin
                state_next = (job_reg == rar_pkg::JOB_ADD_INT) ? rar_pkg::BK_DONE
                                                                : rar_pkg::BK_GCD;
            end
            rar_pkg::BK_GCD: begin
                if (a_reg == 64'd0 || b_reg == 64'd0) begin
                    state_next = rar_pkg::BK_SHIFT;
                end
            end
            rar_pkg::BK_SHIFT: begin
                if (k_reg == 6'd0) begin
                    state_next = rar_pkg::BK_DIV;
                end
            end
            rar_pkg::BK_DIV: begin
                if (div_cnt_reg == 6'd0) begin
                    state_next = rar_pkg::BK_DONE;
                end
            end
            rar_pkg::BK_DONE: begin
                if (load_out) begin
                    state_next = rar_pkg::BK_IDLE;
                end
            end
            default: state_next = rar_pkg::BK_IDLE;
        endcase
    end

    // Handshake outputs of the state machine.
    always_comb begin
        q_pop    = (state_reg == rar_pkg::BK_IDLE) && q_valid;
        load_out = (state_reg == rar_pkg::BK_DONE) && (!out_valid_reg || m_axis_tready);
    end

    always_comb begin
        case (mul_cnt_reg)
            2'd0:    begin mul_a = ln_reg; mul_b = rd_reg; end
            2'd1:    begin mul_a = rn_reg; mul_b = ld_reg; end
            default: begin mul_a = ld_reg; mul_b = rd_reg; end
        endcase
        product = mul_a * mul_b;
    end

    assign g_ext    = {1'b0, g_reg};
    assign remn_sh  = {remn_reg[63:0], qn_reg[63]};
    assign remd_sh  = {remd_reg[63:0], qd_reg[63]};
    assign sum_mag  = sum_reg[64] ? (~sum_reg + 65'd1) : sum_reg;
    assign dsrc_mag = dsrc_reg[63] ? (~dsrc_reg + 64'd1) : dsrc_reg;

    // Final packing: a reduced fraction for reduce and add, else the stored result.
    always_comb begin
        fin_fit = rar_pkg::fits_width(nneg_reg, qn_reg, VALUE_WIDTH)
               && rar_pkg::fits_width(dneg_reg, qd_reg, VALUE_WIDTH);
        if (job_reg == rar_pkg::JOB_REDUCE || job_reg == rar_pkg::JOB_ADD) begin
            fin_num = fin_fit ? rar_pkg::to_signed32(nneg_reg, qn_reg) : 32'd0;
            fin_den = fin_fit ? rar_pkg::to_signed32(dneg_reg, qd_reg) : 32'd0;
            fin_st  = fin_fit ? rar_pkg::ST_OK : rar_pkg::ST_OVERFLOW;
        end else begin
            fin_num = res_num_reg;
            fin_den = res_den_reg;
            fin_st  = res_st_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rar_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            rar_pkg::BK_IDLE: begin
                if (q_pop) begin
                    job_reg     <= q_entry.job;
                    ln_reg      <= q_entry.ln;
                    ld_reg      <= q_entry.ld;
                    rn_reg      <= q_entry.rn;
                    rd_reg      <= q_entry.rd;
                    res_eq_reg  <= q_entry.is_equal;
                    res_st_reg  <= q_entry.status;
                    res_num_reg <= 32'd0;
                    res_den_reg <= 32'd0;
                    mul_cnt_reg <= (q_entry.job == rar_pkg::JOB_ADD_INT) ? 2'd1 : 2'd0;
                end
            end
            rar_pkg::BK_MUL: begin
                case (mul_cnt_reg)
                    2'd0:    prod_a_reg <= product;
                    2'd1:    prod_b_reg <= product;
                    default: prod_c_reg <= product;
                endcase
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
            end
            rar_pkg::BK_SUM: begin
                case (job_reg)
                    rar_pkg::JOB_ADD: begin
                        sum_reg  <= 65'(prod_a_reg) + 65'(prod_b_reg);
                        dsrc_reg <= prod_c_reg;
                    end
                    rar_pkg::JOB_ADD_INT: begin
                        sum_reg  <= 65'(ln_reg) + 65'(prod_b_reg);
                        dsrc_reg <= 64'(ld_reg);
                    end
                    default: begin
                        sum_reg  <= 65'(ln_reg);
                        dsrc_reg <= 64'(ld_reg);
                    end
                endcase
            end
            rar_pkg::BK_PREP: begin
                nneg_reg <= sum_reg[64];
                dneg_reg <= dsrc_reg[63];
                a_reg    <= sum_mag[63:0];
                b_reg    <= dsrc_mag;
                qn_reg   <= sum_mag[63:0];
                qd_reg   <= dsrc_mag;
                k_reg    <= 6'd0;
                if (rar_pkg::fits_width(sum_reg[64], sum_mag[63:0], VALUE_WIDTH)) begin
                    res_num_reg <= rar_pkg::to_signed32(sum_reg[64], sum_mag[63:0]);
                    res_den_reg <= ld_reg;
                end else begin
                    res_st_reg <= rar_pkg::ST_OVERFLOW;
                end
            end
            rar_pkg::BK_GCD: begin
                if (a_reg == 64'd0) begin
                    g_reg <= b_reg;
                end else if (b_reg == 64'd0) begin
                    g_reg <= a_reg;
                end else if (!a_reg[0] && !b_reg[0]) begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                    k_reg <= k_reg + 6'd1;
                end else if (!a_reg[0]) begin
                    a_reg <= a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_reg <= b_reg >> 1;
                end else if (a_reg >= b_reg) begin
                    a_reg <= (a_reg - b_reg) >> 1;
                end else begin
                    b_reg <= (b_reg - a_reg) >> 1;
                end
            end
            rar_pkg::BK_SHIFT: begin
                if (k_reg != 6'd0) begin
                    g_reg <= g_reg << 1;
                    k_reg <= k_reg - 6'd1;
                end else begin
                    remn_reg    <= 65'd0;
                    remd_reg    <= 65'd0;
                    div_cnt_reg <= 6'd63;
                end
            end
            rar_pkg::BK_DIV: begin
                if (remn_sh >= g_ext) begin
                    remn_reg <= remn_sh - g_ext;
                    qn_reg   <= {qn_reg[62:0], 1'b1};
                end else begin
                    remn_reg <= remn_sh;
                    qn_reg   <= {qn_reg[62:0], 1'b0};
                end
                if (remd_sh >= g_ext) begin
                    remd_reg <= remd_sh - g_ext;
                    qd_reg   <= {qd_reg[62:0], 1'b1};
                end else begin
                    remd_reg <= remd_sh;
                    qd_reg   <= {qd_reg[62:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_num_reg <= fin_num;
            out_den_reg <= fin_den;
            out_eq_reg  <= res_eq_reg;
            out_st_reg  <= fin_st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_eq_reg, out_den_reg, out_num_reg};
    assign m_axis_tuser  = out_st_reg;

    `RAR_ASSERT_SAME(a_err_zero, aclk, aresetn, out_valid_reg && out_st_reg != rar_pkg::ST_OK, out_num_reg == 32'd0 && out_den_reg == 32'd0, "error beat with nonzero fraction")
    `RAR_ASSERT_SAME(a_div_nonzero, aclk, aresetn, state_reg == rar_pkg::BK_DIV, g_reg != 64'd0, "division by zero gcd")
    `RAR_ASSERT_NEXT(a_pop_leaves_idle, aclk, aresetn, q_pop, state_reg != rar_pkg::BK_IDLE, "engine stayed idle after pop")

endmodule

// ===== rtl/rational_add_reduce_unit.sv =====
// Top level of the rational add/reduce unit.
`timescale 1ns / 1ps
//
// Input beats arrive on the s_axis channel: tuser carries the action (reduce,
// add, add integer, compare) and tdata the four 32-bit operand fields. Results
// leave on the m_axis channel, one beat for every input beat, in order.
// The front end classifies each beat in the cycle it is accepted and queues
// it in a two-entry job queue. Compare and zero-denominator beats bypass the
// arithmetic. Add-integer takes one product and skips the gcd and division.
// Reduce and add run a binary gcd on 64-bit magnitudes, one step per cycle,
// then a shift that restores the common power of two and a 64-bit
// bit-serial division; the engine works on one item at a time.
// Reset clears the queue, the engine state and the output valid; no clearing
// pass is needed. When the receiver stalls, the finished beat holds in the
// output register, the engine waits with its next result, and input beats
// are still taken until the queue fills.
//
module rational_add_reduce_unit #(
    parameter int VALUE_WIDTH = rar_pkg::VALUE_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_num, left_den, right_num, right_den
    input  logic [127:0] s_axis_tdata,
    // action
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_num, result_den, is_equal, zero fill
    output logic [71:0]  m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);

    logic                q_full;
    logic                q_push;
    rar_pkg::job_entry_t q_in;
    logic                q_pop;
    logic                q_valid;
    rar_pkg::job_entry_t q_head;

    rar_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_in)
    );

    rar_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    rar_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== verif/rar_checker.sv =====
// Checker that predicts and compares the result beats of the rational add/reduce unit.
`timescale 1ns / 1ps

module rar_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [71:0]  m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    output int           fail_count,
    output int           pending_count
);

    typedef struct packed {
        logic [31:0]      num;
        logic [31:0]      den;
        logic             eq;
        rar_pkg::status_t st;
    } rational_result_t;

    rational_result_t awaited_results[$];

    initial fail_count = 0;
    initial pending_count = 0;

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic fits32(input logic neg, input logic [63:0] mag);
        return neg ? (mag <= 64'h8000_0000) : (mag < 64'h8000_0000);
    endfunction

    function automatic rational_result_t reduced(input logic nneg, input logic [63:0] nmag,
                                                 input logic dneg, input logic [63:0] dmag);
        rational_result_t r;
        logic [63:0] g;
        r = '0;
        g = gcd64(nmag, dmag);
        if (g > 1) begin
            nmag = nmag / g;
            dmag = dmag / g;
        end
        if (!fits32(nneg, nmag) || !fits32(dneg, dmag)) begin
            r.st = rar_pkg::ST_OVERFLOW;
        end else begin
            r.num = nneg ? (32'd0 - nmag[31:0]) : nmag[31:0];
            r.den = dneg ? (32'd0 - dmag[31:0]) : dmag[31:0];
            r.st = rar_pkg::ST_OK;
        end
        return r;
    endfunction

    function automatic rational_result_t predict_rational(input rar_pkg::action_t act,
                                                          input logic [127:0] d);
        rational_result_t r;
        logic signed [63:0] ln, ld, rn, rd, p1, p2, pd, s;
        logic [63:0] u;
        logic nneg;
        r = '0;
        ln = $signed(d[31:0]);
        ld = $signed(d[63:32]);
        rn = $signed(d[95:64]);
        rd = $signed(d[127:96]);
        case (act)
            rar_pkg::ACT_REDUCE: begin
                if (ld == 0) r.st = rar_pkg::ST_ZERO_DEN;
                else r = reduced(ln < 0, mag_of(ln), ld < 0, mag_of(ld));
            end
            rar_pkg::ACT_ADD: begin
                if (ld == 0 || rd == 0) begin
                    r.st = rar_pkg::ST_ZERO_DEN;
                end else begin
                    p1 = ln * rd;
                    p2 = rn * ld;
                    pd = ld * rd;
                    u = p1 + p2;
                    if (p1 >= 0 && p2 >= 0) nneg = 1'b0;
                    else nneg = u[63];
                    r = reduced(nneg, nneg ? (64'd0 - u) : u, pd < 0, mag_of(pd));
                end
            end
            rar_pkg::ACT_ADD_INT: begin
                if (ld == 0) begin
                    r.st = rar_pkg::ST_ZERO_DEN;
                end else begin
                    s = ln + rn * ld;
                    if (!fits32(s < 0, mag_of(s))) begin
                        r.st = rar_pkg::ST_OVERFLOW;
                    end else begin
                        r.num = s[31:0];
                        r.den = ld[31:0];
                    end
                end
            end
            default: r.eq = (ln == rn && ld == rd);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        rational_result_t w;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(predict_rational(
                    rar_pkg::action_t'(s_axis_tuser), s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'd0);
                end else begin
                    w = awaited_results.pop_front();
                    if (m_axis_tdata[31:0] !== w.num)
                        report_mismatch("result_num", m_axis_tdata[31:0], w.num);
                    if (m_axis_tdata[63:32] !== w.den)
                        report_mismatch("result_den", m_axis_tdata[63:32], w.den);
                    if (m_axis_tdata[64] !== w.eq)
                        report_mismatch("is_equal", {31'd0, m_axis_tdata[64]},
                                        {31'd0, w.eq});
                    if (m_axis_tuser !== w.st)
                        report_mismatch("status", {30'd0, m_axis_tuser}, {30'd0, w.st});
                end
            end
            pending_count = awaited_results.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top that drives the rational add/reduce unit and gives the verdict.
`timescale 1ns / 1ps

module tb;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    int           fail_count;
    int           pending_count;
    int           beat_index = 0;
    logic         calm = 1'b0;
    logic         hold_off = 1'b0;

    always #5 aclk = ~aclk;

    rational_add_reduce_unit dut (.*);
    rar_checker checker_inst (.*);

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'hffff_ffff;
            4: return 32'd1;
            5, 6: return $urandom_range(0, 60) - 30;
            7: return $urandom_range(0, 2000) - 1000;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_beat(input rar_pkg::action_t act, input logic [31:0] ln,
                             input logic [31:0] ld, input logic [31:0] rn,
                             input logic [31:0] rd);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {rd, rn, ld, ln};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        beat_index++;
    endtask

    always @(negedge aclk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else if (calm) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        #30ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [31:0] a, b, c, d;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_beat(rar_pkg::ACT_REDUCE, 32'd6, 32'd4, 0, 0);
        send_beat(rar_pkg::ACT_REDUCE, 32'h8000_0000, 32'hffff_ffff, 0, 0);
        send_beat(rar_pkg::ACT_REDUCE, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_beat(rar_pkg::ACT_REDUCE, 32'd0, 32'hffff_fffd, 0, 0);
        send_beat(rar_pkg::ACT_REDUCE, 32'd5, 32'd0, 0, 0);
        send_beat(rar_pkg::ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_beat(rar_pkg::ACT_ADD, 32'd1, 32'd2, 32'hffff_ffff, 32'd2);
        send_beat(rar_pkg::ACT_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send_beat(rar_pkg::ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000);
        send_beat(rar_pkg::ACT_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_beat(rar_pkg::ACT_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
        send_beat(rar_pkg::ACT_ADD, 32'd1, 32'd3, 32'd1, 32'd0);
        send_beat(rar_pkg::ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd3);
        send_beat(rar_pkg::ACT_ADD_INT, 32'd1, 32'd3, 32'd2, 0);
        send_beat(rar_pkg::ACT_ADD_INT, 32'h7fff_ffff, 32'd1, 32'd1, 0);
        send_beat(rar_pkg::ACT_ADD_INT, 32'h8000_0000, 32'hffff_ffff, 32'd0, 0);
        send_beat(rar_pkg::ACT_ADD_INT, 32'd1, 32'd0, 32'd1, 0);
        send_beat(rar_pkg::ACT_COMPARE, 32'd3, 32'd0, 32'd3, 32'd0);
        send_beat(rar_pkg::ACT_COMPARE, 32'd3, 32'd4, 32'd3, 32'd5);
        send_beat(rar_pkg::ACT_COMPARE, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff,
                  32'h8000_0000);
        // Hold the receiver off long enough for the queue to fill and stall input.
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(negedge aclk);
                hold_off = 1'b0;
            end
            repeat (8) send_beat(rar_pkg::action_t'($urandom_range(0, 3)), pick_value(),
                                 pick_value(), pick_value(), pick_value());
        join
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        while (beat_index < 1470) begin
            if (beat_index > 1350) calm = 1'b1;
            a = pick_value();
            b = pick_value();
            c = pick_value();
            d = pick_value();
            if ($urandom_range(0, 7) == 0) begin
                c = a;
                d = b;
            end
            send_beat(rar_pkg::action_t'($urandom_range(0, 3)), a, b, c, d);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (500) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
